FILE: hdl/bdq_pkg.sv
// Package for the bounded deque: command and status codes, transfer structs
// and the control word between controller and datapath. No dependencies.
package bdq_pkg;

  localparam int WORD_W  = 32;
  localparam int LEVEL_W = 8;

  typedef enum logic [1:0] {
    CMD_PUSH_BACK  = 2'd0,
    CMD_PUSH_FRONT = 2'd1,
    CMD_POP_FRONT  = 2'd2,
    CMD_POP_BACK   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_t;

  typedef struct packed {
    cmd_t                     cmd;
    logic signed [WORD_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    status_t                  status;
    logic signed [WORD_W-1:0] popped;
    logic [LEVEL_W-1:0]       level;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic finish;
  } ctrl_cmd_t;

endpackage

FILE: hdl/bdq_ctrl.sv
// Controller of the bounded deque: sequences one transfer through
// capture, execute and finish. Depends on bdq_pkg.
module bdq_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  output logic                out_strobe,
  output bdq_pkg::ctrl_cmd_t  ctrl
);
  import bdq_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_FINISH
  } state_t;

  state_t state_r;
  logic   busy_r;
  logic   strobe_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      busy_r   <= 1'b0;
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (start) begin
            state_r <= S_EXEC;
            busy_r  <= 1'b1;
          end
        end
        S_EXEC: begin
          state_r <= S_FINISH;
        end
        S_FINISH: begin
          state_r  <= S_IDLE;
          busy_r   <= 1'b0;
          strobe_r <= 1'b1;
        end
        default: begin
          state_r <= S_IDLE;
          busy_r  <= 1'b0;
        end
      endcase
    end
  end

  assign ctrl.load   = (state_r == S_IDLE) && start;
  assign ctrl.exec   = (state_r == S_EXEC);
  assign ctrl.finish = (state_r == S_FINISH);
  assign busy        = busy_r;
  assign out_strobe  = strobe_r;

endmodule

FILE: hdl/bdq_dpath.sv
// Datapath of the bounded deque: ring store, head and fill registers and the
// result register. Depends on bdq_pkg and is driven by bdq_ctrl.
module bdq_dpath #(
  parameter int DEPTH = 128
) (
  input  logic                clk,
  input  logic                rst_n,
  input  bdq_pkg::ctrl_cmd_t  ctrl,
  input  bdq_pkg::in_item_t   in_data,
  output bdq_pkg::out_item_t  out_data
);
  import bdq_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = CW + 1;
  localparam logic [SW-1:0] DEPTH_S = SW'(DEPTH);

  logic [WORD_W-1:0] mem [DEPTH];

  cmd_t                     cmd_r;
  logic signed [WORD_W-1:0] value_r;
  logic [AW-1:0]            head_r;
  logic [CW-1:0]            fill_r;
  logic [AW-1:0]            head_nxt;
  logic [CW-1:0]            fill_nxt;
  status_t                  status_r;
  logic                     pop_ok_r;
  logic [WORD_W-1:0]        rd_data_r;
  out_item_t                out_r;

  logic          full;
  logic          empty;
  logic          wr_en;
  logic          rd_en;
  logic [AW-1:0] addr;
  logic [AW-1:0] head_dec;
  logic [AW-1:0] head_inc;
  logic [SW-1:0] back_sum;
  logic [AW-1:0] back_idx;
  logic [SW-1:0] last_sum;
  logic [AW-1:0] last_idx;
  status_t       status_nxt;

  assign full    = (fill_r == CW'(DEPTH));
  assign empty   = (fill_r == '0);

  assign head_dec = (head_r == '0) ? AW'(DEPTH - 1) : head_r - AW'(1);
  assign head_inc = (head_r == AW'(DEPTH - 1)) ? '0 : head_r + AW'(1);

  assign back_sum = SW'(head_r) + SW'(fill_r);
  assign back_idx = (back_sum >= DEPTH_S) ? AW'(back_sum - DEPTH_S) : AW'(back_sum);
  assign last_sum = back_sum - SW'(1);
  assign last_idx = (last_sum >= DEPTH_S) ? AW'(last_sum - DEPTH_S) : AW'(last_sum);

  always_comb begin
    status_nxt = ST_OK;
    wr_en      = 1'b0;
    rd_en      = 1'b0;
    addr       = head_r;
    head_nxt   = head_r;
    fill_nxt   = fill_r;
    case (cmd_r)
      CMD_PUSH_BACK: begin
        if (full) begin
          status_nxt = ST_OVERFLOW;
        end else begin
          wr_en    = 1'b1;
          addr     = back_idx;
          fill_nxt = fill_r + CW'(1);
        end
      end
      CMD_PUSH_FRONT: begin
        if (full) begin
          status_nxt = ST_OVERFLOW;
        end else begin
          wr_en    = 1'b1;
          addr     = head_dec;
          head_nxt = head_dec;
          fill_nxt = fill_r + CW'(1);
        end
      end
      CMD_POP_FRONT: begin
        if (empty) begin
          status_nxt = ST_UNDERFLOW;
        end else begin
          rd_en    = 1'b1;
          addr     = head_r;
          head_nxt = head_inc;
          fill_nxt = fill_r - CW'(1);
        end
      end
      CMD_POP_BACK: begin
        if (empty) begin
          status_nxt = ST_UNDERFLOW;
        end else begin
          rd_en    = 1'b1;
          addr     = last_idx;
          fill_nxt = fill_r - CW'(1);
        end
      end
      default: begin
        status_nxt = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctrl.exec && wr_en) begin
      mem[addr] <= value_r;
    end
    if (ctrl.exec && rd_en) begin
      rd_data_r <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      fill_r <= '0;
    end else if (ctrl.exec) begin
      head_r <= head_nxt;
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      cmd_r   <= in_data.cmd;
      value_r <= in_data.value;
    end
    if (ctrl.exec) begin
      status_r <= status_nxt;
      pop_ok_r <= rd_en;
    end
    if (ctrl.finish) begin
      out_r.status <= status_r;
      out_r.popped <= pop_ok_r ? rd_data_r : '0;
      out_r.level  <= LEVEL_W'(fill_r);
    end
  end

  assign out_data = out_r;

endmodule

FILE: hdl/bounded_deque.sv
// Top level of the bounded deque: joins the controller and the datapath.
// Depends on bdq_pkg, bdq_ctrl and bdq_dpath.
//
// A fixed-capacity double-ended queue of signed 32-bit words held in a ring.
// An input transfer happens at a rising edge where start is high and busy is
// low; in_data carries the command (push back, push front, pop front, pop
// back) and the word to push. Each input transfer yields exactly one result
// on out_data, shown for one cycle while out_strobe is high: the status
// (ok, overflow or underflow), the popped word (zero unless a pop succeeded)
// and the fill level after the command.
// Timing: the item is captured at the accepting edge, executed against the
// store in the next cycle (one synchronous memory access), and the result is
// registered at the end of the finish state, at the same edge at which
// out_strobe rises. busy stays high through the execute and finish states,
// and a new item can be taken in the cycle in which the result is shown;
// no new item is taken before then.
// Reset (rst_n low, synchronous) empties the deque and drops any item in
// progress; the store contents need no clearing. The receiver cannot stall
// the block; a result must be taken in the cycle it is shown.
module bounded_deque #(
  parameter int DEPTH = 128
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  bdq_pkg::in_item_t   in_data,
  output logic                out_strobe,
  output bdq_pkg::out_item_t  out_data
);
  import bdq_pkg::*;

  ctrl_cmd_t ctrl;

  bdq_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .out_strobe (out_strobe),
    .ctrl       (ctrl)
  );

  bdq_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (ctrl),
    .in_data  (in_data),
    .out_data (out_data)
  );

endmodule

FILE: hdl/bdq_checker.sv
// Port-level checker for the bounded deque and its bind to the top level.
// Depends on bdq_pkg and bounded_deque.
module bdq_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input logic                out_strobe,
  input bdq_pkg::out_item_t  out_data
);
  import bdq_pkg::*;

  logic in_xfer;
  assign in_xfer = start && !busy;

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> ##2 out_strobe)
    else $error("result did not follow an input transfer");

  a_busy_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> busy)
    else $error("busy not raised after an input transfer");

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !busy)
    else $error("result shown while busy");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("result strobe held for more than one cycle");

  a_fail_no_word: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && (out_data.status != ST_OK)) |-> (out_data.popped == '0))
    else $error("failed command returned a nonzero word");

endmodule

bind bounded_deque bdq_checker u_bdq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .out_strobe (out_strobe),
  .out_data   (out_data)
);

FILE: tb/bounded_deque_tb.sv
// Testbench for bounded_deque: directed tests of the deque ends, empty and
// full cases, then biased random command streams under varied sender idling.
// Depends on bdq_pkg and the bounded_deque RTL.
`timescale 1ns / 1ps

module bounded_deque_tb;
  import bdq_pkg::*;

  localparam int DEPTH       = 128;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SEGMENT_LEN = 170;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  in_item_t  in_data = '0;
  logic      out_strobe;
  out_item_t out_data;

  logic signed [WORD_W-1:0] ring_words [DEPTH];
  int                       ring_head = 0;
  int                       ring_fill = 0;
  out_item_t                pending_results [$];
  int                       fail_count = 0;
  int                       cycle_count = 0;
  int                       idle_pct = 0;

  bounded_deque #(.DEPTH(DEPTH)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_strobe(out_strobe),
    .out_data  (out_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("** bounded_deque: FAILED **");
      $finish;
    end
  end

  function automatic out_item_t apply_command(in_item_t item);
    out_item_t res;
    res.status = ST_OK;
    res.popped = '0;
    case (item.cmd)
      CMD_PUSH_BACK, CMD_PUSH_FRONT: begin
        if (ring_fill >= DEPTH) begin
          res.status = ST_OVERFLOW;
        end else if (item.cmd == CMD_PUSH_BACK) begin
          ring_words[(ring_head + ring_fill) % DEPTH] = item.value;
          ring_fill++;
        end else begin
          ring_head = (ring_head + DEPTH - 1) % DEPTH;
          ring_words[ring_head] = item.value;
          ring_fill++;
        end
      end
      CMD_POP_FRONT, CMD_POP_BACK: begin
        if (ring_fill == 0) begin
          res.status = ST_UNDERFLOW;
        end else if (item.cmd == CMD_POP_FRONT) begin
          res.popped = ring_words[ring_head];
          ring_head = (ring_head + 1) % DEPTH;
          ring_fill--;
        end else begin
          res.popped = ring_words[(ring_head + ring_fill - 1) % DEPTH];
          ring_fill--;
        end
      end
      default: begin
        res.status = ST_OK;
      end
    endcase
    res.level = LEVEL_W'(ring_fill);
    return res;
  endfunction

  function automatic logic signed [WORD_W-1:0] pick_word();
    case ($urandom_range(7))
      0: return 32'sh7fff_ffff;
      1: return 32'sh8000_0000;
      2: return '0;
      3: return -32'sd1;
      default: return $signed($urandom());
    endcase
  endfunction

  // Start stays high from one transfer to the next unless an idle gap is drawn.
  task automatic send_command(input cmd_t cmd, input logic signed [WORD_W-1:0] value);
    in_item_t item;
    item.cmd   = cmd;
    item.value = value;
    start   <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_results.push_back(apply_command(item));
    while ($urandom_range(99) < idle_pct) begin
      start   <= 1'b0;
      in_data <= '{cmd: cmd_t'($urandom_range(3)), value: $signed($urandom())};
      @(posedge clk);
    end
  endtask

  always @(posedge clk) begin : check_results
    out_item_t want;
    if (rst_n && out_strobe) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: status %0d popped %0d level %0d",
               out_data.status, out_data.popped, out_data.level);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_data.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_data.status);
          fail_count++;
        end
        if (out_data.popped !== want.popped) begin
          $error("popped: expected %0d, got %0d", want.popped, out_data.popped);
          fail_count++;
        end
        if (out_data.level !== want.level) begin
          $error("level: expected %0d, got %0d", want.level, out_data.level);
          fail_count++;
        end
      end
    end
  end

  task automatic test_empty_underflow();
    send_command(CMD_POP_FRONT, 32'sh1234_5678);
    send_command(CMD_POP_BACK, -32'sd1);
  endtask

  task automatic test_both_ends();
    send_command(CMD_PUSH_BACK, 32'sh7fff_ffff);
    send_command(CMD_PUSH_FRONT, 32'sh8000_0000);
    send_command(CMD_PUSH_BACK, '0);
    send_command(CMD_PUSH_FRONT, -32'sd1);
    send_command(CMD_PUSH_BACK, 32'sh5a5a_5a5a);
    send_command(CMD_PUSH_FRONT, 32'sha5a5_a5a5);
    send_command(CMD_POP_FRONT, '0);
    send_command(CMD_POP_BACK, '0);
    send_command(CMD_POP_FRONT, '0);
    send_command(CMD_POP_BACK, '0);
    send_command(CMD_POP_FRONT, '0);
    send_command(CMD_POP_FRONT, '0);
    send_command(CMD_POP_BACK, '0);
    send_command(CMD_POP_FRONT, '0);
  endtask

  // The deque is filled from both ends so the ring wraps, pushed past full,
  // then drained from both ends past empty.
  task automatic test_full_overflow();
    for (int i = 0; i < DEPTH; i++) begin
      send_command((i % 3 == 0) ? CMD_PUSH_FRONT : CMD_PUSH_BACK, pick_word());
    end
    send_command(CMD_PUSH_BACK, 32'sh0f0f_0f0f);
    send_command(CMD_PUSH_FRONT, 32'shf0f0_f0f0);
    for (int i = 0; i < DEPTH; i++) begin
      send_command((i % 2 == 0) ? CMD_POP_BACK : CMD_POP_FRONT, pick_word());
    end
    send_command(CMD_POP_FRONT, '0);
  endtask

  task automatic test_random_stream(input int pct_idle);
    int push_pct;
    idle_pct = pct_idle;
    for (int seg = 0; seg < 2; seg++) begin
      push_pct = (seg == 0) ? 90 : 10;
      for (int i = 0; i < SEGMENT_LEN; i++) begin
        if ($urandom_range(99) < push_pct) begin
          send_command($urandom_range(1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK, pick_word());
        end else begin
          send_command($urandom_range(1) ? CMD_POP_FRONT : CMD_POP_BACK, pick_word());
        end
      end
    end
    idle_pct = 0;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    test_empty_underflow();
    test_both_ends();
    test_full_overflow();
    test_random_stream(0);
    test_random_stream(60);
    test_random_stream(16);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("** bounded_deque: PASSED **");
    end else begin
      $display("** bounded_deque: FAILED **");
    end
    $finish;
  end

endmodule
